FILE: rtl/core/mpf_pkg.sv
// Package for the page-organized monochrome framebuffer.
// Holds default geometry, opcodes, controller states and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package mpf_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 64;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    FUNC_SPAN  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SPAN  = 5'b00010,
    ST_CLEAR = 5'b00100,
    ST_READ  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  typedef struct packed {
    logic item_load;
    logic span_step;
    logic clr_init;
    logic clr_step;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic span_last;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/mono_page_framebuffer_top.sv
// Top level of the page-organized monochrome framebuffer.
// Instantiates mpf_ctrl and mpf_datapath; depends on mpf_pkg.
//
// One item is taken at a time. A span is accepted and then steps through its
// source bits (at least one step), since each column byte is read and written
// back through the store's separate read and write ports in a pipelined
// read-modify-write. A clear is accepted and then zeroes all
// SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) store bytes, one byte per cycle. A flush
// is accepted, reads the store and loads the output register, and waits before
// the load only while the previous byte is still held on the output. After
// reset the same clearing sweep runs over the whole store before the first
// item is taken.
`default_nettype none

module mono_page_framebuffer_top #(
  parameter int unsigned SCREEN_WIDTH  = mpf_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mpf_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // source_bits[7:0], bit_count[11:8], start_x[20:12], start_y[29:21],
  // pixel_color[30], zero[31]
  input  wire logic [mpf_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // func[1:0]
  input  wire logic [mpf_pkg::IN_TUSER_W-1:0] s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // pixel_byte[7:0]
  output logic [mpf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);

  mpf_pkg::cmd_t    cmd;
  mpf_pkg::status_t status;

  mpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_func_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpf_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mpf_ctrl.sv
// Controller state machine of the framebuffer.
// Sequences span, clear and flush items; drives datapath commands.
// Depends on mpf_pkg.
`default_nettype none

module mpf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [1:0]       in_func_i,
  output logic                  in_ready_o,
  input  wire mpf_pkg::status_t status_i,
  output mpf_pkg::cmd_t         cmd_o
);

  mpf_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mpf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          unique case (mpf_pkg::func_e'(in_func_i))
            mpf_pkg::FUNC_SPAN:  state_d = mpf_pkg::ST_SPAN;
            mpf_pkg::FUNC_CLEAR: begin
              cmd_o.clr_init = 1'b1;
              state_d        = mpf_pkg::ST_CLEAR;
            end
            mpf_pkg::FUNC_FLUSH: state_d = mpf_pkg::ST_READ;
            default:             state_d = mpf_pkg::ST_IDLE;
          endcase
        end
      end
      mpf_pkg::ST_SPAN: begin
        cmd_o.span_step = 1'b1;
        if (status_i.span_last) state_d = mpf_pkg::ST_IDLE;
      end
      mpf_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = mpf_pkg::ST_IDLE;
      end
      mpf_pkg::ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = mpf_pkg::ST_OUT;
      end
      mpf_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mpf_pkg::ST_IDLE;
        end
      end
      default: state_d = mpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpf_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpf_pkg::ST_READ |=> state_q == mpf_pkg::ST_OUT)
    else $error("read cycle not followed by output state");

  a_span_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpf_pkg::ST_SPAN && status_i.span_last) |=> state_q == mpf_pkg::ST_IDLE)
    else $error("span did not return to idle");

endmodule

`default_nettype wire

FILE: rtl/core/mpf_datapath.sv
// Datapath of the framebuffer: frame store memory, span read-modify-write
// pipeline, clear sweep counter, readout index and output register.
// Depends on mpf_pkg.
`default_nettype none

module mpf_datapath #(
  parameter int unsigned SCREEN_WIDTH  = mpf_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mpf_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [mpf_pkg::IN_TDATA_W-1:0]      in_data_i,
  input  wire mpf_pkg::cmd_t                       cmd_i,
  output mpf_pkg::status_t                         status_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [mpf_pkg::OUT_TDATA_W-1:0]          out_data_o,
  output logic                                     out_last_o
);

  localparam int unsigned PageCount  = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned StoreBytes = SCREEN_WIDTH * PageCount;
  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned ColW       = $clog2(SCREEN_WIDTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreBytes - 1);

  logic [7:0] mem [StoreBytes];
  logic [7:0] rd_q;

  // span item registers
  logic [7:0]        sh_q, sh_d;
  logic [3:0]        count_q, count_d;
  logic [3:0]        k_q, k_d;
  logic signed [9:0] col_q, col_d;
  logic [AddrW-1:0]  base_q, base_d;
  logic              row_ok_q, row_ok_d;
  logic [7:0]        mask_q, mask_d;
  logic              lit_q, lit_d;

  logic              wp_q, wp_d;
  logic [AddrW-1:0]  wa_q, wa_d;

  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic [AddrW-1:0]  idx_q, idx_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic [8:0]        in_y;
  logic              col_ok, hit;
  logic [AddrW-1:0]  span_addr;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_wa, mem_ra;
  logic [7:0]        mem_wd;

  assign in_y = in_data_i[29:21];

  assign col_ok    = ~col_q[9] && (col_q[8:0] < 9'(SCREEN_WIDTH));
  assign hit       = cmd_i.span_step && (k_q < count_q) && sh_q[7] && col_ok && row_ok_q;
  assign span_addr = base_q + AddrW'(col_q[ColW-1:0]);

  always_comb begin
    sh_d     = sh_q;
    count_d  = count_q;
    k_d      = k_q;
    col_d    = col_q;
    base_d   = base_q;
    row_ok_d = row_ok_q;
    mask_d   = mask_q;
    lit_d    = lit_q;
    if (cmd_i.item_load) begin
      sh_d     = in_data_i[7:0];
      count_d  = (in_data_i[11:8] > 4'd8) ? 4'd8 : in_data_i[11:8];
      k_d      = '0;
      col_d    = $signed({in_data_i[20], in_data_i[20:12]});
      row_ok_d = ~in_y[8] && (in_y[7:0] < 8'(SCREEN_HEIGHT));
      base_d   = AddrW'(AddrW'(in_y[7:3]) * AddrW'(SCREEN_WIDTH));
      mask_d   = 8'd1 << in_y[2:0];
      lit_d    = in_data_i[30];
    end else if (cmd_i.span_step) begin
      sh_d  = {sh_q[6:0], 1'b0};
      k_d   = k_q + 4'd1;
      col_d = col_q + 10'sd1;
    end
  end

  assign status_o.span_last = (5'(k_q) + 5'd1) >= 5'(count_q);
  assign status_o.clr_last  = clr_addr_q == LastAddr;
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

  assign wp_d = hit;
  assign wa_d = span_addr;

  always_comb begin
    clr_addr_d = clr_addr_q;
    if (cmd_i.clr_init) begin
      clr_addr_d = '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_d = (clr_addr_q == LastAddr) ? '0 : clr_addr_q + AddrW'(1);
    end
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wa_q;
    mem_wd = lit_q ? (rd_q | mask_q) : (rd_q & ~mask_q);
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '0;
    end else if (wp_q) begin
      mem_we = 1'b1;
    end
    mem_re = hit | cmd_i.rd_issue;
    mem_ra = cmd_i.rd_issue ? idx_q : span_addr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_comb begin
    idx_d       = idx_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = rd_q;
      out_last_d  = idx_q == LastAddr;
      idx_d       = (idx_q == LastAddr) ? '0 : idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q       <= sh_d;
    count_q    <= count_d;
    k_q        <= k_d;
    col_q      <= col_d;
    base_q     <= base_d;
    row_ok_q   <= row_ok_d;
    mask_q     <= mask_d;
    lit_q      <= lit_d;
    wa_q       <= wa_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= 1'b0;
      clr_addr_q  <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      clr_addr_q  <= clr_addr_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_step && wp_q))
    else $error("clear sweep and span write in the same cycle");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q |-> $past(mem_re) && !$past(cmd_i.rd_issue))
    else $error("span write without a preceding span read");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (~out_valid_q | out_ready_i))
    else $error("output register overwritten");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for mono_page_framebuffer_top: spans, clears and flush reads.
// A scoreboard class mirrors the page store and checks every flushed byte.
// Depends on mpf_pkg and the RTL top level only.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SCR_W      = mpf_pkg::SCREEN_WIDTH_DEF;
  localparam int unsigned SCR_H      = mpf_pkg::SCREEN_HEIGHT_DEF;
  localparam int unsigned PAGES      = (SCR_H + 7) / 8;
  localparam int unsigned STORE_SIZE = SCR_W * PAGES;
  localparam int unsigned RUN_ITEMS  = 1950;
  localparam int unsigned LIMIT_CYC  = 800000;
  localparam logic [1:0]  FUNC_NONE  = 2'd3;

  typedef struct {
    logic [7:0] pixel_byte;
    logic       last_byte;
  } flush_byte_t;

  class page_scoreboard;
    logic [7:0]   pixel_pages [STORE_SIZE];
    int unsigned  flush_ptr;
    flush_byte_t  pending_bytes [$];
    int unsigned  fail_count;

    function new();
      foreach (pixel_pages[i]) pixel_pages[i] = '0;
      flush_ptr  = 0;
      fail_count = 0;
    endfunction

    function void flag(string what, logic [7:0] exp_b, logic exp_l,
                       logic [7:0] got_b, logic got_l);
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                 $realtime, what, exp_b, exp_l, got_b, got_l);
    endfunction

    function void note_transfer(logic [1:0] func, logic [31:0] data);
      logic [7:0]  bits;
      int unsigned cnt;
      int          x0;
      int          y0;
      int          x;
      int unsigned addr;
      flush_byte_t e;
      case (func)
        mpf_pkg::FUNC_SPAN: begin
          bits = data[7:0];
          cnt  = data[11:8];
          if (cnt > 8) cnt = 8;
          x0 = $signed(data[20:12]);
          y0 = $signed(data[29:21]);
          for (int k = 0; k < cnt; k++) begin
            x = x0 + k;
            if (bits[7-k] && x >= 0 && x < SCR_W && y0 >= 0 && y0 < SCR_H) begin
              addr = x + (y0 / 8) * SCR_W;
              pixel_pages[addr][y0 % 8] = data[30];
            end
          end
        end
        mpf_pkg::FUNC_CLEAR: begin
          foreach (pixel_pages[i]) pixel_pages[i] = '0;
        end
        mpf_pkg::FUNC_FLUSH: begin
          e.pixel_byte = pixel_pages[flush_ptr];
          e.last_byte  = (flush_ptr == STORE_SIZE - 1);
          pending_bytes.push_back(e);
          flush_ptr = (flush_ptr == STORE_SIZE - 1) ? 0 : flush_ptr + 1;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] got_b, logic got_l);
      flush_byte_t e;
      if (pending_bytes.size() == 0) begin
        flag("unexpected transfer", 'x, 'x, got_b, got_l);
        return;
      end
      e = pending_bytes.pop_front();
      if (got_b !== e.pixel_byte || got_l !== e.last_byte)
        flag("mismatch", e.pixel_byte, e.last_byte, got_b, got_l);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int unsigned    src_idle;
  int unsigned    dst_idle;
  page_scoreboard sb;

  mono_page_framebuffer_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  initial begin
    repeat (LIMIT_CYC) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] span_word(logic [7:0] bits, int unsigned cnt,
                                            int x, int y, logic color);
    logic [8:0] x9;
    logic [8:0] y9;
    logic [3:0] c4;
    x9 = x[8:0];
    y9 = y[8:0];
    c4 = cnt[3:0];
    return {1'b0, color, y9, x9, c4, bits};
  endfunction

  task automatic send_item(input logic [1:0] func, input logic [31:0] data);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle && gap < 40) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= func;
    do @(posedge clk_i); while (!s_tready);
    sb.note_transfer(func, data);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_span(logic [7:0] bits, int unsigned cnt, int x, int y, logic color);
    send_item(mpf_pkg::FUNC_SPAN, span_word(bits, cnt, x, y, color));
  endtask

  task automatic random_item();
    int unsigned pick;
    int          x;
    int          y;
    int unsigned cnt;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_item(mpf_pkg::FUNC_FLUSH, {1'b0, 31'($urandom)});
    end else if (pick < 96) begin
      x   = ($urandom_range(99) < 85) ? int'($urandom_range(143)) - 8
                                      : int'($urandom_range(511)) - 256;
      y   = ($urandom_range(99) < 85) ? int'($urandom_range(71)) - 4
                                      : int'($urandom_range(511)) - 256;
      cnt = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(15);
      send_span(8'($urandom_range(255)), cnt, x, y, $urandom_range(99) < 75);
    end else if (pick < 98) begin
      send_item(mpf_pkg::FUNC_CLEAR, {1'b0, 31'($urandom)});
    end else begin
      send_item(FUNC_NONE, {1'b0, 31'($urandom)});
    end
  endtask

  initial begin
    sb       = new();
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = mpf_pkg::FUNC_SPAN;
    src_idle = 24;
    dst_idle = 54;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_span(8'hFF, 8, 0, 0, 1'b1);
    send_span(8'hFF, 8, 120, 63, 1'b1);
    send_span(8'hFF, 8, 124, 7, 1'b1);
    send_span(8'hFF, 8, -3, 8, 1'b1);
    send_span(8'hFF, 8, -256, 0, 1'b1);
    send_span(8'hFF, 8, 255, 255, 1'b1);
    send_span(8'hFF, 8, 10, -1, 1'b1);
    send_span(8'hFF, 8, 10, -256, 1'b1);
    send_span(8'hFF, 8, 10, 64, 1'b1);
    send_span(8'hFF, 0, 20, 20, 1'b1);
    send_span(8'hA5, 15, 1, 9, 1'b1);
    send_span(8'h5A, 9, 0, 2, 1'b1);
    send_span(8'h81, 8, 0, 0, 1'b0);
    send_span(8'h00, 8, 0, 1, 1'b1);
    send_item(FUNC_NONE, 32'h7FFF_FFFF);
    repeat (4) send_item(mpf_pkg::FUNC_FLUSH, '0);
    send_item(mpf_pkg::FUNC_CLEAR, '0);
    repeat (2) send_item(mpf_pkg::FUNC_FLUSH, '0);
    send_span(8'hC0, 2, 6, 0, 1'b1);
    repeat (2) send_item(mpf_pkg::FUNC_FLUSH, '0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 24 : (phase == 1) ? 54 : 0;
      dst_idle = (phase == 0) ? 54 : (phase == 1) ? 24 : 0;
      for (int n = 0; n < RUN_ITEMS / 3; n++) random_item();
      drain();
    end

    repeat (1100) @(posedge clk_i);
    if (sb.pending_bytes.size() != 0)
      sb.flag("missing transfer", sb.pending_bytes[0].pixel_byte,
              sb.pending_bytes[0].last_byte, 'x, 'x);
    if (sb.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
